>>> rtl/ljpf_pkg.sv
package ljpf_pkg;

   localparam int FRAC_BITS = 24;

   localparam int POS_W    = 32;
   localparam int SIGSQ_W  = 40;
   localparam int SHIFT_W  = 48;
   localparam int SUM_W    = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_BOX_SIZE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIGMA_SQ     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WELL_DEPTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CUTOFF_SQ    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ENERGY_SHIFT = 3'd4;

   localparam logic [31:0] BOX_RESET   = 32'd167772160;
   localparam logic [39:0] SIGSQ_RESET = 40'd16777216;
   localparam logic [31:0] EPS_RESET   = 32'd16777216;
   localparam logic [39:0] CUT_RESET   = 40'd104857600;
   localparam logic [47:0] SHIFT_RESET = 48'hFFFF_FFFB_D2A5; // -273755

   localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [63:0] val;
      logic        clip;
   } sat64_type;

   // signed saturating add
   function automatic sat64_type add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      sat64_type   r;
      s = {a[63], a} + {b[63], b};
      r.clip = (s[64] != s[63]);
      r.val  = r.clip ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
      return r;
   endfunction

   // magnitude and sign to int64, clipping the magnitude at 2^63-1
   function automatic sat64_type to_signed(input logic neg, input logic [63:0] mag);
      logic [63:0] m;
      sat64_type   r;
      r.clip = mag[63];
      m      = r.clip ? S64_MAX : mag;
      r.val  = neg ? (64'd0 - m) : m;
      return r;
   endfunction

endpackage

>>> rtl/lj_pair_force_accumulator_unit.sv
// Lennard-Jones pair force accumulator (2-D, shifted potential).
// req_* carries one candidate pair per transfer: positions of particle i and
// of one neighbour j; req_tlast marks the final neighbour of particle i.
// rsp_* carries one result per particle: summed force x/y and half the summed
// shifted pair energy, with rsp_tuser set if any term or sum saturated.
// csr_* writes the box size, sigma squared, epsilon, cutoff squared and the
// energy shift; write only while the block is idle. csr_ready is always high.
// Each pair runs through one shared 32x32 multiplier and one bit-serial
// divider under a sequencer: a minimum image per axis and, for a pair inside
// the cutoff, two divisions plus seven 64x64 products. req_tready is high
// only between pairs.
// A result sits in the output register until taken; the next pair is worked
// on meanwhile, and only its emission waits on a stalled receiver.
// Reset restores the register defaults, clears the sums and drops rsp_tvalid.
module lj_pair_force_accumulator_unit
   import ljpf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [127:0]         req_tdata,  // own_x, own_y, other_x, other_y
   input  logic                 req_tlast,  // last_pair
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [191:0]         rsp_tdata,  // force_x, force_y, pair_energy
   output logic                 rsp_tuser,  // saturated
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SHIFT_W-1:0]   csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_MIX_LD, S_MIX_RUN, S_MIX_FIN, S_SQX, S_SQY, S_SUMR, S_CHECK,
      S_OP, S_DIV, S_MUL, S_WB, S_EFIN, S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_S2, OP_SQ, OP_S6, OP_S12, OP_FE, OP_FD, OP_FX, OP_FY, OP_EN
   } op_type;

   state_type state_ff;
   op_type    op_ff;

   logic [31:0]  box_ff, eps_ff;
   logic [39:0]  sigsq_ff, cut_ff;
   logic [47:0]  shift_ff;
   logic [63:0]  sfx_ff, sfy_ff, sen_ff;
   logic         clip_ff;

   logic [127:0] pos_ff;
   logic         last_ff;
   logic         axis_ff;
   logic         neg_ff;
   logic [31:0]  ux_ff, uy_ff;
   logic         dxneg_ff, dyneg_ff;
   logic [39:0]  r2_ff;
   logic [63:0]  s2_ff, t_ff, s6_ff, s12_ff, fm_ff;
   logic         fneg_ff;
   logic [63:0]  opa_ff, opb_ff;
   logic [63:0]  pp_ff;
   logic [127:0] acc_ff;
   logic [40:0]  rem_ff, dd_ff;
   logic [63:0]  dvd_ff;
   logic [6:0]   cnt_ff, cnt_last_ff;
   logic         div_op_ff, div_sat_ff;

   logic         rsp_valid_ff;
   logic [191:0] rsp_data_ff;
   logic         rsp_user_ff;

   // combinational
   logic [31:0]  mul_a, mul_b;
   logic [32:0]  box_ext;
   logic [31:0]  own_v, oth_v;
   logic         mix_neg;
   logic [31:0]  mix_u;
   logic [41:0]  div_t;
   logic         div_ge;
   logic [33:0]  rem_twice;
   logic         mix_corr;
   logic [32:0]  box_less;
   logic [63:0]  mul_res, div_res, res;
   logic         mul_clip;
   logic [63:0]  t2;
   logic         t2_clip, f_neg, e_neg;
   logic [63:0]  f_mag, e_mag;
   logic [68:0]  f24;
   logic [63:0]  f24_v, e4_v;
   logic         f24_clip, e4_clip;
   logic [63:0]  r2raw;
   logic [63:0]  neg_shift;
   logic [63:0]  e_half;
   sat64_type    ts_x, ts_y, ts_e, as_x, as_y, as_e1, as_e2;
   logic [63:0]  div_x;
   logic [39:0]  r2_next;
   logic         wb_clip;

   assign box_ext = (box_ff == 32'd0) ? {1'b1, 32'd0} : {1'b0, box_ff};

   always_comb begin
      own_v = axis_ff ? pos_ff[63:32]  : pos_ff[31:0];
      oth_v = axis_ff ? pos_ff[127:96] : pos_ff[95:64];
      mix_neg = own_v < oth_v;
      mix_u   = mix_neg ? (oth_v - own_v) : (own_v - oth_v);
   end

   assign div_t  = {rem_ff, dvd_ff[63]};
   assign div_ge = div_t >= {1'b0, dd_ff};

   always_comb begin
      rem_twice = {rem_ff[32:0], 1'b0};
      mix_corr  = (rem_twice > {1'b0, box_ext})
                  || ((rem_twice == {1'b0, box_ext}) && dvd_ff[0]);
      box_less  = box_ext - rem_ff[32:0];
   end

   always_comb begin
      case (state_ff)
         S_SQX: begin
            mul_a = ux_ff;
            mul_b = ux_ff;
         end
         S_SQY: begin
            mul_a = uy_ff;
            mul_b = uy_ff;
         end
         default: begin
            mul_a = cnt_ff[1] ? opa_ff[63:32] : opa_ff[31:0];
            mul_b = cnt_ff[0] ? opb_ff[63:32] : opb_ff[31:0];
         end
      endcase
   end

   always_comb begin
      mul_clip = |acc_ff[127:64+FRAC_BITS];
      mul_res  = mul_clip ? '1 : acc_ff[FRAC_BITS +: 64];
      div_res  = div_sat_ff ? '1 : dvd_ff;
      res      = div_op_ff ? div_res : mul_res;
   end

   always_comb begin
      t2_clip  = s12_ff[63];
      t2       = t2_clip ? '1 : {s12_ff[62:0], 1'b0};
      f_neg    = t2 < s6_ff;
      f_mag    = f_neg ? (s6_ff - t2) : (t2 - s6_ff);
      f24      = ({5'd0, f_mag} << 4) + ({5'd0, f_mag} << 3);
      f24_clip = |f24[68:64];
      f24_v    = f24_clip ? '1 : f24[63:0];
      e_neg    = s12_ff < s6_ff;
      e_mag    = e_neg ? (s6_ff - s12_ff) : (s12_ff - s6_ff);
      e4_clip  = |e_mag[63:62];
      e4_v     = e4_clip ? '1 : {e_mag[61:0], 2'b00};
   end

   always_comb begin
      r2raw     = acc_ff[63:0];
      r2_next   = r2raw[FRAC_BITS +: 40];
      neg_shift = 64'd0 - {{(64-SHIFT_W){shift_ff[SHIFT_W-1]}}, shift_ff};
      ts_x  = to_signed(fneg_ff ^ dxneg_ff, mul_res);
      ts_y  = to_signed(fneg_ff ^ dyneg_ff, mul_res);
      ts_e  = to_signed(e_neg, mul_res);
      as_x  = add_sat(sfx_ff, ts_x.val);
      as_y  = add_sat(sfy_ff, ts_y.val);
      as_e1 = add_sat(ts_e.val, neg_shift);
      e_half = $signed(t_ff + {63'd0, t_ff[63]}) >>> 1;
      as_e2 = add_sat(sen_ff, e_half);
      div_x = (op_ff == OP_S2) ? {24'd0, sigsq_ff} : fm_ff;
   end

   // saturation seen at write-back of the current op
   always_comb begin
      case (op_ff)
         OP_FX:   wb_clip = ts_x.clip || as_x.clip;
         OP_FY:   wb_clip = ts_y.clip || as_y.clip;
         OP_EN:   wb_clip = ts_e.clip || as_e1.clip;
         default: wb_clip = 1'b0;
      endcase
      if (!div_op_ff && mul_clip)
         wb_clip = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_S2;
         box_ff       <= BOX_RESET;
         sigsq_ff     <= SIGSQ_RESET;
         eps_ff       <= EPS_RESET;
         cut_ff       <= CUT_RESET;
         shift_ff     <= SHIFT_RESET;
         sfx_ff       <= '0;
         sfy_ff       <= '0;
         sen_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_BOX_SIZE:     box_ff   <= csr_data[31:0];
               REG_SIGMA_SQ:     sigsq_ff <= csr_data[39:0];
               REG_WELL_DEPTH:   eps_ff   <= csr_data[31:0];
               REG_CUTOFF_SQ:    cut_ff   <= csr_data[39:0];
               REG_ENERGY_SHIFT: shift_ff <= csr_data;
               default: ;
            endcase
         end
         // a result loaded in S_EMIT takes over the slot in the same cycle
         if (rsp_valid_ff && rsp_tready && !(state_ff == S_EMIT && last_ff))
            rsp_valid_ff <= 1'b0;

         if (state_ff != S_SQX && state_ff != S_SQY)
            pp_ff <= mul_a * mul_b;
         else
            pp_ff <= mul_a * mul_b;

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  pos_ff   <= req_tdata;
                  last_ff  <= req_tlast;
                  axis_ff  <= 1'b0;
                  state_ff <= S_MIX_LD;
               end
            end
            S_MIX_LD: begin
               neg_ff      <= mix_neg;
               rem_ff      <= '0;
               dvd_ff      <= {mix_u, 32'd0};
               dd_ff       <= {8'd0, box_ext};
               cnt_ff      <= '0;
               cnt_last_ff <= 7'd31;
               state_ff    <= S_MIX_RUN;
            end
            S_MIX_RUN, S_DIV: begin
               rem_ff <= div_ge ? (div_t[40:0] - dd_ff) : div_t[40:0];
               dvd_ff <= {dvd_ff[62:0], div_ge};
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == cnt_last_ff)
                  state_ff <= (state_ff == S_DIV) ? S_WB : S_MIX_FIN;
            end
            S_MIX_FIN: begin
               if (!axis_ff) begin
                  ux_ff    <= mix_corr ? box_less[31:0] : rem_ff[31:0];
                  dxneg_ff <= mix_corr ? !neg_ff : neg_ff;
                  axis_ff  <= 1'b1;
                  state_ff <= S_MIX_LD;
               end else begin
                  uy_ff    <= mix_corr ? box_less[31:0] : rem_ff[31:0];
                  dyneg_ff <= mix_corr ? !neg_ff : neg_ff;
                  state_ff <= S_SQX;
               end
            end
            S_SQX: state_ff <= S_SQY;
            S_SQY: begin
               acc_ff   <= {64'd0, pp_ff};
               state_ff <= S_SUMR;
            end
            S_SUMR: begin
               acc_ff   <= acc_ff + {64'd0, pp_ff};
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (r2raw != 64'd0 && r2_next < cut_ff) begin
                  r2_ff    <= (r2_next == 40'd0) ? 40'd1 : r2_next;
                  op_ff    <= OP_S2;
                  state_ff <= S_OP;
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            S_OP: begin
               acc_ff <= '0;
               cnt_ff <= '0;
               if (op_ff == OP_S2 || op_ff == OP_FD) begin
                  div_op_ff   <= 1'b1;
                  rem_ff      <= {17'd0, div_x[63:64-FRAC_BITS]};
                  dvd_ff      <= div_x << FRAC_BITS;
                  dd_ff       <= {1'b0, r2_ff};
                  cnt_last_ff <= 7'd63;
                  if ({16'd0, div_x[63:64-FRAC_BITS]} >= r2_ff) begin
                     div_sat_ff <= 1'b1;
                     clip_ff    <= 1'b1;
                     state_ff   <= S_WB;
                  end else begin
                     div_sat_ff <= 1'b0;
                     state_ff   <= S_DIV;
                  end
               end else begin
                  div_op_ff <= 1'b0;
                  state_ff  <= S_MUL;
                  case (op_ff)
                     OP_SQ: begin
                        opa_ff <= s2_ff;
                        opb_ff <= s2_ff;
                     end
                     OP_S6: begin
                        opa_ff <= t_ff;
                        opb_ff <= s2_ff;
                     end
                     OP_S12: begin
                        opa_ff <= s6_ff;
                        opb_ff <= s6_ff;
                     end
                     OP_FE: begin
                        opa_ff  <= f24_v;
                        opb_ff  <= {32'd0, eps_ff};
                        fneg_ff <= f_neg;
                        if (t2_clip || f24_clip)
                           clip_ff <= 1'b1;
                     end
                     OP_FX: begin
                        opa_ff <= fm_ff;
                        opb_ff <= {32'd0, ux_ff};
                     end
                     OP_FY: begin
                        opa_ff <= fm_ff;
                        opb_ff <= {32'd0, uy_ff};
                     end
                     OP_EN: begin
                        opa_ff <= e4_v;
                        opb_ff <= {32'd0, eps_ff};
                        if (e4_clip)
                           clip_ff <= 1'b1;
                     end
                     default: begin
                        opa_ff <= fm_ff;
                        opb_ff <= fm_ff;
                     end
                  endcase
               end
            end
            S_MUL: begin
               // products issue on counts 0..3, accumulate on 1..4
               cnt_ff <= cnt_ff + 7'd1;
               case (cnt_ff[2:0])
                  3'd1: acc_ff <= acc_ff + {64'd0, pp_ff};
                  3'd2, 3'd3: acc_ff <= acc_ff + {32'd0, pp_ff, 32'd0};
                  3'd4: begin
                     acc_ff   <= acc_ff + {pp_ff, 64'd0};
                     state_ff <= S_WB;
                  end
                  default: ;
               endcase
            end
            S_WB: begin
               if (wb_clip)
                  clip_ff <= 1'b1;
               op_ff    <= op_type'(op_ff + 4'd1);
               state_ff <= (op_ff == OP_EN) ? S_EFIN : S_OP;
               case (op_ff)
                  OP_S2:  s2_ff  <= res;
                  OP_SQ:  t_ff   <= res;
                  OP_S6:  s6_ff  <= res;
                  OP_S12: s12_ff <= res;
                  OP_FE:  fm_ff  <= res;
                  OP_FD:  fm_ff  <= res;
                  OP_FX:  sfx_ff <= as_x.val;
                  OP_FY:  sfy_ff <= as_y.val;
                  OP_EN:  t_ff   <= as_e1.val;
                  default: ;
               endcase
            end
            S_EFIN: begin
               sen_ff <= as_e2.val;
               if (as_e2.clip)
                  clip_ff <= 1'b1;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {sen_ff, sfy_ff, sfx_ff};
                  rsp_user_ff  <= clip_ff;
                  sfx_ff       <= '0;
                  sfy_ff       <= '0;
                  sen_ff       <= '0;
                  clip_ff      <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
   import ljpf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [63:0] fx;
      logic [63:0] fy;
      logic [63:0] energy;
      logic        sat;
   } particle_sum_type;

   class lj_scoreboard;
      logic [31:0]      box;
      logic [63:0]      sig2, eps, cut2;
      longint           eshift;
      longint           acc_fx, acc_fy, acc_e;
      bit               acc_clip, clip_now;
      particle_sum_type sums_due[$];
      int               errors, results, pairs;

      function void restore();
         box = BOX_RESET; sig2 = SIGSQ_RESET; eps = EPS_RESET; cut2 = CUT_RESET;
         eshift = longint'(signed'(SHIFT_RESET));
         acc_fx = 0; acc_fy = 0; acc_e = 0; acc_clip = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [47:0] v);
         case (idx)
            REG_BOX_SIZE:     box = v[31:0];
            REG_SIGMA_SQ:     sig2 = {24'd0, v[39:0]};
            REG_WELL_DEPTH:   eps = {32'd0, v[31:0]};
            REG_CUTOFF_SQ:    cut2 = {24'd0, v[39:0]};
            REG_ENERGY_SHIFT: eshift = longint'({{16{v[47]}}, v});
            default: ;
         endcase
      endfunction

      function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         if (p[127:88] != 0) begin
            clip_now = 1;
            return '1;
         end
         return p[87:24];
      endfunction

      function logic [63:0] kmul(logic [63:0] a, logic [63:0] k);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, k};
         if (p[127:64] != 0) begin
            clip_now = 1;
            return '1;
         end
         return p[63:0];
      endfunction

      function logic [63:0] qdiv(logic [63:0] x, logic [63:0] d);
         logic [127:0] num;
         if ({40'd0, x[63:40]} >= d) begin
            clip_now = 1;
            return '1;
         end
         num = {40'd0, x, 24'd0};
         num = num / {64'd0, d};
         return num[63:0];
      endfunction

      function longint signed_mag(bit neg, logic [63:0] mag);
         if (mag[63]) begin
            clip_now = 1;
            mag = S64_MAX;
         end
         return neg ? -longint'(mag) : longint'(mag);
      endfunction

      function longint sat_add(longint a, longint b);
         logic [64:0] s;
         s = {a[63], a} + {b[63], b};
         if (s[64] != s[63]) begin
            clip_now = 1;
            return s[64] ? longint'(S64_MIN) : longint'(S64_MAX);
         end
         return longint'(s[63:0]);
      endfunction

      function longint nearest_image(logic [31:0] own, logic [31:0] other);
         logic [63:0] bx, u, q, r;
         longint      diff, w;
         bit          neg;
         bx = (box != 0) ? {32'd0, box} : 64'h1_0000_0000;
         diff = longint'({32'd0, own}) - longint'({32'd0, other});
         neg = diff < 0;
         u = neg ? -diff : diff;
         q = u / bx;
         r = u % bx;
         // ties round to even, so an exact half box stays uncorrected
         if (2 * r > bx || (2 * r == bx && q[0])) q++;
         w = longint'(u) - longint'(q * bx);
         return neg ? -w : w;
      endfunction

      function void note_pair(logic [127:0] d, bit last);
         longint           dx, dy, e;
         logic [63:0]      ux, uy, r2raw, r2, s2, s6, s12, t2, fm, em;
         bit               fneg, eneg;
         particle_sum_type s;
         pairs++;
         dx = nearest_image(d[31:0], d[95:64]);
         dy = nearest_image(d[63:32], d[127:96]);
         ux = dx < 0 ? -dx : dx;
         uy = dy < 0 ? -dy : dy;
         r2raw = ux * ux + uy * uy;
         clip_now = 0;
         if (r2raw != 0 && (r2raw >> 24) < cut2) begin
            r2 = r2raw >> 24;
            if (r2 == 0) r2 = 1;
            s2 = qdiv(sig2, r2);
            s6 = qmul(qmul(s2, s2), s2);
            s12 = qmul(s6, s6);
            t2 = kmul(s12, 2);
            fneg = t2 < s6;
            fm = fneg ? s6 - t2 : t2 - s6;
            fm = qdiv(qmul(kmul(fm, 24), eps), r2);
            acc_fx = sat_add(acc_fx, signed_mag(fneg != (dx < 0), qmul(fm, ux)));
            acc_fy = sat_add(acc_fy, signed_mag(fneg != (dy < 0), qmul(fm, uy)));
            eneg = s12 < s6;
            em = eneg ? s6 - s12 : s12 - s6;
            em = qmul(kmul(em, 4), eps);
            e = signed_mag(eneg, em);
            e = sat_add(e, -eshift);
            e = e / 2;
            acc_e = sat_add(acc_e, e);
         end
         if (clip_now) acc_clip = 1;
         if (last) begin
            s.fx = acc_fx; s.fy = acc_fy; s.energy = acc_e; s.sat = acc_clip;
            sums_due.push_back(s);
            acc_fx = 0; acc_fy = 0; acc_e = 0; acc_clip = 0;
         end
      endfunction

      function void check_result(logic [191:0] d, logic sat);
         particle_sum_type x;
         results++;
         if (sums_due.size() == 0) begin
            $display("%0t: unexpected result fx=%h fy=%h e=%h sat=%b", $time,
                     d[63:0], d[127:64], d[191:128], sat);
            errors++;
            return;
         end
         x = sums_due.pop_front();
         if (d[63:0] !== x.fx) begin
            $display("%0t: force_x exp %h got %h", $time, x.fx, d[63:0]);
            errors++;
         end
         if (d[127:64] !== x.fy) begin
            $display("%0t: force_y exp %h got %h", $time, x.fy, d[127:64]);
            errors++;
         end
         if (d[191:128] !== x.energy) begin
            $display("%0t: pair_energy exp %h got %h", $time, x.energy, d[191:128]);
            errors++;
         end
         if (sat !== x.sat) begin
            $display("%0t: saturated exp %b got %b", $time, x.sat, sat);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_tvalid = 0, req_tready, req_tlast = 0;
   logic [127:0]         req_tdata = '0;
   logic                 rsp_tvalid, rsp_tready = 0, rsp_tuser;
   logic [191:0]         rsp_tdata;
   logic                 csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SHIFT_W-1:0]   csr_data = '0;

   lj_scoreboard sb = new();
   bit           rsp_hold_free = 0;
   int           rsp_wait = 0;

   lj_pair_force_accumulator_unit i_dut (.*);

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_pair(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // receiver back-pressure: random stalls, none while hold_free is set
   always @(negedge clock) begin
      if (rsp_hold_free) begin
         rsp_tready <= 1;
      end else if (rsp_wait > 0) begin
         rsp_tready <= 0;
         rsp_wait   <= rsp_wait - 1;
      end else begin
         rsp_tready <= 1;
         rsp_wait   <= pick_gap();
      end
   end

   task automatic send_pair(logic [31:0] ox, logic [31:0] oy, logic [31:0] nx,
                            logic [31:0] ny, bit last);
      int g;
      req_tdata = {ny, nx, oy, ox};
      req_tlast = last;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      g = pick_gap();
      if (g > 0) begin
         req_tvalid = 0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid = 0;
      while (sb.sums_due.size() != 0) @(negedge clock);
      // a trailing non-last pair may still be in flight
      repeat (400) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [47:0] v);
      csr_index = idx;
      csr_data = v;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic setup(logic [31:0] bx, logic [39:0] s2, logic [31:0] ep,
                        logic [39:0] c2, logic [47:0] sh);
      drain();
      write_csr(REG_BOX_SIZE, {16'd0, bx});
      write_csr(REG_SIGMA_SQ, {8'd0, s2});
      write_csr(REG_WELL_DEPTH, {16'd0, ep});
      write_csr(REG_CUTOFF_SQ, {8'd0, c2});
      write_csr(REG_ENERGY_SHIFT, sh);
   endtask

   task automatic random_pairs(int n);
      logic [31:0] ox, oy, nx, ny;
      for (int k = 0; k < n; k++) begin
         ox = $urandom; oy = $urandom;
         if ($urandom_range(9) < 7) begin
            // neighbor close enough to fall inside typical cutoffs
            nx = ox + $urandom_range(0, 32'h0600_0000) - 32'h0300_0000;
            ny = oy + $urandom_range(0, 32'h0600_0000) - 32'h0300_0000;
         end else begin
            nx = $urandom; ny = $urandom;
         end
         send_pair(ox, oy, nx, ny, $urandom_range(3) == 0);
      end
      send_pair($urandom, $urandom, $urandom, $urandom, 1);
   endtask

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      sb.restore();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset settings (box 10.0, cutoff 2.5)
      send_pair(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 1); // zero
      send_pair(32'h0, 32'h0, 32'h0500_0000, 32'h0, 0);             // half box
      send_pair(32'h0, 32'h0, 32'h0280_0000, 32'h0, 0);             // at cutoff
      send_pair(32'h0, 32'h0, 32'h027F_FFFF, 32'h0, 1);             // just inside
      send_pair(32'h0300_0000, 32'h0, 32'h0300_0001, 32'h0, 1);     // sub-LSB r2
      send_pair(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 0);     // field extremes
      send_pair(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1);
      send_pair(32'h0120_0000, 32'h0, 32'h0, 32'h0110_0000, 0);
      send_pair(32'h0, 32'h0, 32'h0100_0000, 32'h0080_0000, 1);
      send_pair(32'h0, 32'h0, 32'h0900_0000, 32'h0, 1);             // wraps to 1.0
      send_pair(32'h0, 32'h0, 32'h0A00_0000, 32'h0, 1);             // nothing added

      // extreme settings: clipping everywhere
      setup(32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF,
            48'h8000_0000_0000);
      write_csr(3'd5, 48'hFFFF_FFFF_FFFF);  // unmapped index, ignored
      write_csr(3'd7, 48'h0);
      send_pair(32'h0, 32'h0, 32'h0000_0001, 32'h0, 1);
      send_pair(32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 0);
      send_pair(32'h1234_5678, 32'h0, 32'h1234_0000, 32'h0, 1);
      random_pairs(30);

      // smallest settings
      setup(32'h0100_0000, 40'd1, 32'd0, 40'd1, 48'h7FFF_FFFF_FFFF);
      send_pair(32'h0, 32'h0, 32'h0080_0000, 32'h0, 0);             // exact half box
      send_pair(32'h0, 32'h0, 32'h0000_0100, 32'h0, 1);
      random_pairs(30);

      rsp_hold_free = 1;
      setup(BOX_RESET, SIGSQ_RESET, EPS_RESET, CUT_RESET, SHIFT_RESET);
      random_pairs(120);
      rsp_hold_free = 0;
      drain();  // let every result out before continuing
      random_pairs(60);

      for (int p = 0; p < 3; p++) begin
         setup($urandom_range(32'h0100_0000, 32'hFFFF_FFFF),
               {8'd0, $urandom_range(1, 32'h0400_0000)}, $urandom,
               {8'($urandom_range(0, 3)), $urandom}, 48'({$urandom, $urandom} >> 16));
         random_pairs(50);
      end

      drain();
      $display("Checked %0d pairs and %0d particle results over seven register settings",
               sb.pairs, sb.results);
      $display("(reset, extreme, minimal and random box, sigma, epsilon, cutoff, shift).");
      if (sb.errors == 0 && sb.sums_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

>>> lj_pair_force_accumulator_unit.f
rtl/ljpf_pkg.sv
rtl/lj_pair_force_accumulator_unit.sv
tb/sv/tb_top.sv
